>>> rtl/core/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared types and constants for the six-byte utf-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned CP_W  = 31;
  localparam int unsigned LEN_W = 3;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_BAD_CONT  = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  // one input byte of the stream
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } byte_req_t;

  // one decoded result
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    status_t          status;
    logic [LEN_W-1:0] sequence_length;
    logic             result_last;
  } result_t;

endpackage

>>> rtl/core/utf8sd_stream_if.sv
// ----------------------------------------------------------------------------
// utf8sd_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface utf8sd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Decodes a utf-8 byte stream (one to six byte sequences) into code points.
// ----------------------------------------------------------------------------
// results: the result for the byte that completes or breaks a sequence is
//   registered in the output register, or in the skid entry while that is stalled
// throughput: one byte per cycle while the skid entry is empty; the byte decode and
//   state update sit between the sequence state registers and a two-entry result buffer
// reset: rst (synchronous) empties the result buffer and returns to idle
module utf8_stream_decoder_top (
  input  logic               clk,
  input  logic               rst,
  utf8sd_stream_if.sink      byte_ch,
  utf8sd_stream_if.source    result_ch
);

  // sequence state
  logic [utf8sd_pkg::CP_W-1:0]  acc;
  logic [utf8sd_pkg::LEN_W-1:0] expected;
  logic [utf8sd_pkg::LEN_W-1:0] seen;
  logic [utf8sd_pkg::CP_W-1:0]  acc_next;
  logic [utf8sd_pkg::LEN_W-1:0] expected_next;
  logic [utf8sd_pkg::LEN_W-1:0] seen_next;

  // result buffer: output register plus skid entry
  utf8sd_pkg::result_t out_reg;
  utf8sd_pkg::result_t skid_reg;
  logic                out_valid;
  logic                skid_valid;

  logic                accept;
  logic                pop;
  logic                has_result;
  utf8sd_pkg::result_t res;
  logic [7:0]          b;
  logic                last;
  logic [utf8sd_pkg::LEN_W-1:0] lead_len;
  logic [6:0]          lead_bits;
  logic [utf8sd_pkg::LEN_W-1:0] seen_inc;
  logic [utf8sd_pkg::CP_W-1:0]  acc_shift;

  assign b      = byte_ch.data.data_byte;
  assign last   = byte_ch.data.stream_end;
  assign byte_ch.ready = !skid_valid;
  assign accept = byte_ch.valid && byte_ch.ready;
  assign pop    = out_valid && result_ch.ready;

  assign result_ch.valid = out_valid;
  assign result_ch.data  = out_reg;

  // lead byte class and its payload bits
  always_comb begin
    lead_len  = '0;
    lead_bits = '0;
    unique case (b) inside
      8'b0???????: begin lead_len = 3'd1; lead_bits = b[6:0];         end
      8'b110?????: begin lead_len = 3'd2; lead_bits = {2'b0, b[4:0]}; end
      8'b1110????: begin lead_len = 3'd3; lead_bits = {3'b0, b[3:0]}; end
      8'b11110???: begin lead_len = 3'd4; lead_bits = {4'b0, b[2:0]}; end
      8'b111110??: begin lead_len = 3'd5; lead_bits = {5'b0, b[1:0]}; end
      8'b1111110?: begin lead_len = 3'd6; lead_bits = {6'b0, b[0]};   end
      default:     begin lead_len = '0;   lead_bits = '0;             end
    endcase
  end

  assign seen_inc  = seen + 3'd1;
  assign acc_shift = {acc[utf8sd_pkg::CP_W-7:0], b[5:0]};

  // byte decode and next sequence state
  always_comb begin
    acc_next        = acc;
    expected_next   = expected;
    seen_next       = seen;
    has_result      = 1'b0;
    res.code_point  = '0;
    res.status      = utf8sd_pkg::ST_OK;
    res.sequence_length = '0;
    res.result_last = last;
    if (expected == '0) begin
      if (lead_len == '0) begin
        has_result = 1'b1;
        res.status = utf8sd_pkg::ST_BAD_LEAD;
      end else if (lead_len == 3'd1) begin
        has_result          = 1'b1;
        res.code_point      = {{(utf8sd_pkg::CP_W-7){1'b0}}, lead_bits};
        res.sequence_length = 3'd1;
      end else if (last) begin
        has_result          = 1'b1;
        res.status          = utf8sd_pkg::ST_TRUNCATED;
        res.sequence_length = 3'd1;
      end else begin
        acc_next      = {{(utf8sd_pkg::CP_W-7){1'b0}}, lead_bits};
        expected_next = lead_len;
        seen_next     = 3'd1;
      end
    end else if (b[7:6] != 2'b10) begin
      has_result          = 1'b1;
      res.status          = utf8sd_pkg::ST_BAD_CONT;
      res.sequence_length = seen_inc;
      expected_next       = '0;
      seen_next           = '0;
    end else if (seen_inc >= expected) begin
      has_result          = 1'b1;
      res.code_point      = acc_shift;
      res.sequence_length = seen_inc;
      expected_next       = '0;
      seen_next           = '0;
    end else if (last) begin
      has_result          = 1'b1;
      res.status          = utf8sd_pkg::ST_TRUNCATED;
      res.sequence_length = seen_inc;
      expected_next       = '0;
      seen_next           = '0;
    end else begin
      acc_next  = acc_shift;
      seen_next = seen_inc;
    end
  end

  // sequence state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= '0;
      seen     <= '0;
    end else if (accept) begin
      expected <= expected_next;
      seen     <= seen_next;
    end
  end

  // accumulator is reloaded by a lead byte that starts a multi-byte sequence
  always_ff @(posedge clk) begin
    if (accept) begin
      acc <= acc_next;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && has_result) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_reg <= skid_reg;
      end
    end else if (accept && has_result) begin
      if (out_valid && !pop) begin
        skid_reg <= res;
      end else begin
        out_reg <= res;
      end
    end
  end

endmodule

>>> rtl/core/utf8sd_checker.sv
// ----------------------------------------------------------------------------
// utf8sd_checker
// Port-level checks on the decoder result channel, bound to the top level.
// ----------------------------------------------------------------------------
module utf8sd_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input utf8sd_pkg::result_t out_data
);

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // any error result carries a zero code point
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != utf8sd_pkg::ST_OK |-> out_data.code_point == '0)
    else $error("error result with nonzero code point");

  // bad lead consumes nothing of a sequence
  a_bad_lead_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == utf8sd_pkg::ST_BAD_LEAD
      |-> out_data.sequence_length == 3'd0)
    else $error("bad lead with nonzero length");

  // other results cover one to six bytes
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != utf8sd_pkg::ST_BAD_LEAD
      |-> out_data.sequence_length != 3'd0 && out_data.sequence_length != 3'd7)
    else $error("sequence length out of range");

  // a one-byte ok result fits in seven bits
  a_ascii: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == utf8sd_pkg::ST_OK && out_data.sequence_length == 3'd1
      |-> out_data.code_point[utf8sd_pkg::CP_W-1:7] == '0)
    else $error("one-byte result above seven bits");

endmodule

bind utf8_stream_decoder_top utf8sd_checker u_utf8sd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .out_data  (result_ch.data)
);
